// ===== rtl/tbt_pkg.sv =====
// ----------------------------------------------------------------------------
// tbt_pkg
// Shared types and constants for the triangle tangent/bitangent block.
// ----------------------------------------------------------------------------
package tbt_pkg;

    localparam int POS_W  = 32;                  // corner position width
    localparam int TEX_W  = 16;                  // corner UV width
    localparam int DP_W   = POS_W + 1;           // position delta
    localparam int DT_W   = TEX_W + 1;           // UV delta
    localparam int PROD_W = DP_W + DT_W;         // one edge product
    localparam int NUM_W  = 49;                  // numerator magnitude bits
    localparam int DET_W  = 35;                  // signed determinant
    localparam int UD_W   = DET_W - 1;           // determinant magnitude
    localparam int Q_W    = 33;                  // quotient kept before rounding
    localparam int N_COMP = 6;                   // tangent xyz, bitangent xyz
    localparam int COMP_W = 3;

    localparam int TEX_FRAC_BITS_DEF = 12;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [TEX_W-1:0] tex_u;
        logic signed [TEX_W-1:0] tex_v;
    } tbt_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] tangent_x;
        logic signed [POS_W-1:0] tangent_y;
        logic signed [POS_W-1:0] tangent_z;
        logic signed [POS_W-1:0] bitangent_x;
        logic signed [POS_W-1:0] bitangent_y;
        logic signed [POS_W-1:0] bitangent_z;
        logic                    degenerate;
        logic                    clipped;
    } tbt_out_t;

    // controller -> datapath
    typedef struct packed {
        logic              store_first;
        logic              store_second;
        logic              capture;      // third corner: form deltas, clear results
        logic              mul_en;
        logic              mul_det;      // operands for the determinant
        logic [COMP_W-1:0] comp;         // component being worked on
        logic              det_en;
        logic              div_start;
        logic              fin_en;
        logic              out_load;
    } tbt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic det_zero;
        logic div_done;
        logic out_busy;
    } tbt_sts_t;

endpackage

// ===== rtl/triangle_tangent_bitangent.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent
// Tangent and bitangent of a UV-mapped triangle, fed one corner per word.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one corner per word (Q16.16 position, Q4.12 UV). Every third
//   corner closes a triangle; the first two are only stored.
//   m_ channel: one word per triangle with the tangent, the bitangent,
//   degenerate (UV determinant zero, vectors zero) and clipped (saturation).
//   First and second corners are taken while idle. A third corner starts
//   the work: s_ready stays low until the result is loaded into the output
//   register. The one-bit-per-cycle divider runs once for each of the six
//   components; a degenerate triangle skips the divider.
//   The result sits in an output register; corners of the next triangle
//   are accepted while it waits. If m_ready stays low, the following
//   triangle finishes its arithmetic and holds until the word is taken.
//   Reset (aresetn low, synchronous) drops m_valid and restarts the corner
//   count, so the next corner is a first corner.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent import tbt_pkg::*; #(
    parameter int TEX_FRAC_BITS = TEX_FRAC_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tbt_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tbt_out_t m_data
);

    tbt_cmd_t cmd;
    tbt_sts_t sts;

    tbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    tbt_dp #(
        .TEX_FRAC_BITS(TEX_FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/tbt_div.sv =====
// ----------------------------------------------------------------------------
// tbt_div
// Restoring divider, one quotient bit per cycle, with overflow sticky.
// ----------------------------------------------------------------------------
module tbt_div import tbt_pkg::*; #(
    parameter int TEX_FRAC_BITS = TEX_FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [UD_W-1:0]  den,
    output logic             done,
    output logic [Q_W-1:0]   quot,
    output logic             big
);

    localparam int DVD_W   = NUM_W + TEX_FRAC_BITS + 1;
    localparam int STEPS   = DVD_W;
    localparam int CNT_W   = $clog2(STEPS);

    logic [DVD_W-1:0] dvd_reg;
    logic [UD_W-1:0]  rem_reg;
    logic [Q_W-1:0]   q_reg;
    logic             big_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [UD_W:0]    trial;
    logic             fits;
    logic [UD_W:0]    diff;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {num, {(TEX_FRAC_BITS + 1){1'b0}}};
            rem_reg <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= fits ? diff[UD_W-1:0] : trial[UD_W-1:0];
            q_reg   <= {q_reg[Q_W-2:0], fits};
            // any bit pushed past the kept width means the quotient is out of range
            big_reg <= big_reg | q_reg[Q_W-1];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign big  = big_reg;

    property p_no_restart;
        @(posedge aclk) disable iff (!aresetn) start |-> !busy_reg;
    endproperty
    a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

    property p_done_after_busy;
        @(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg;
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("done while busy");

    property p_busy_ends;
        @(posedge aclk) disable iff (!aresetn)
            (busy_reg && cnt_reg == '0 && !start) |=> (done_reg && !busy_reg);
    endproperty
    a_busy_ends: assert property (p_busy_ends) else $error("divider did not finish");

endmodule

// ===== rtl/tbt_dp.sv =====
// ----------------------------------------------------------------------------
// tbt_dp
// Datapath: corner store, deltas, shared multiplier pair, divider, output word.
// ----------------------------------------------------------------------------
module tbt_dp import tbt_pkg::*; #(
    parameter int TEX_FRAC_BITS = TEX_FRAC_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  tbt_in_t  s_data,
    input  tbt_cmd_t cmd,
    output tbt_sts_t sts,
    output logic     m_valid,
    input  logic     m_ready,
    output tbt_out_t m_data
);

    logic signed [POS_W-1:0]  p1x_reg, p1y_reg, p1z_reg, p2x_reg, p2y_reg, p2z_reg;
    logic signed [TEX_W-1:0]  t1u_reg, t1v_reg, t2u_reg, t2v_reg;
    logic signed [DP_W-1:0]   dp1_reg [3];
    logic signed [DP_W-1:0]   dp2_reg [3];
    logic signed [DT_W-1:0]   du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [PROD_W-1:0] pa_reg, pb_reg;
    logic signed [DET_W-1:0]  det_reg;
    logic                     neg_reg;
    logic signed [POS_W-1:0]  res_reg [N_COMP];
    logic                     clip_reg;
    tbt_out_t                 out_reg;
    logic                     m_valid_reg;

    logic signed [DP_W-1:0]   mul_a1, mul_a2;
    logic signed [DT_W-1:0]   mul_b1, mul_b2;
    logic [1:0]               axis;
    logic signed [PROD_W:0]   pa_x, pb_x, diff;
    logic [PROD_W:0]          diff_mag;
    logic [DET_W-1:0]         det_mag;
    logic                     div_done, div_big;
    logic [Q_W-1:0]           div_q;
    logic [Q_W:0]             q_inc;
    logic [Q_W-1:0]           q_rnd, limit, mag;
    logic                     sat;
    logic [Q_W-1:0]           val;

    always_ff @(posedge aclk) begin
        if (cmd.store_first) begin
            p1x_reg <= s_data.pos_x;
            p1y_reg <= s_data.pos_y;
            p1z_reg <= s_data.pos_z;
            t1u_reg <= s_data.tex_u;
            t1v_reg <= s_data.tex_v;
        end
        if (cmd.store_second) begin
            p2x_reg <= s_data.pos_x;
            p2y_reg <= s_data.pos_y;
            p2z_reg <= s_data.pos_z;
            t2u_reg <= s_data.tex_u;
            t2v_reg <= s_data.tex_v;
        end
        if (cmd.capture) begin
            dp1_reg[0] <= DP_W'(p2x_reg) - DP_W'(p1x_reg);
            dp1_reg[1] <= DP_W'(p2y_reg) - DP_W'(p1y_reg);
            dp1_reg[2] <= DP_W'(p2z_reg) - DP_W'(p1z_reg);
            dp2_reg[0] <= DP_W'(s_data.pos_x) - DP_W'(p1x_reg);
            dp2_reg[1] <= DP_W'(s_data.pos_y) - DP_W'(p1y_reg);
            dp2_reg[2] <= DP_W'(s_data.pos_z) - DP_W'(p1z_reg);
            du1_reg    <= DT_W'(t2u_reg) - DT_W'(t1u_reg);
            dv1_reg    <= DT_W'(t2v_reg) - DT_W'(t1v_reg);
            du2_reg    <= DT_W'(s_data.tex_u) - DT_W'(t1u_reg);
            dv2_reg    <= DT_W'(s_data.tex_v) - DT_W'(t1v_reg);
        end
    end

    // operand select: determinant, tangent (dv terms) or bitangent (du terms)
    always_comb begin
        axis = (cmd.comp >= COMP_W'(3)) ? 2'(cmd.comp - COMP_W'(3)) : 2'(cmd.comp);
        if (axis > 2'd2) begin
            axis = 2'd0;
        end
        if (cmd.mul_det) begin
            mul_a1 = DP_W'(du1_reg);
            mul_b1 = dv2_reg;
            mul_a2 = DP_W'(dv1_reg);
            mul_b2 = du2_reg;
        end else if (cmd.comp < COMP_W'(3)) begin
            mul_a1 = dp1_reg[axis];
            mul_b1 = dv2_reg;
            mul_a2 = dp2_reg[axis];
            mul_b2 = dv1_reg;
        end else begin
            mul_a1 = dp1_reg[axis];
            mul_b1 = du1_reg;
            mul_a2 = dp2_reg[axis];
            mul_b2 = du2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            pa_reg <= mul_a1 * mul_b1;
            pb_reg <= mul_a2 * mul_b2;
        end
    end

    assign pa_x     = pa_reg;
    assign pb_x     = pb_reg;
    assign diff     = pa_x - pb_x;
    assign diff_mag = diff[PROD_W] ? -diff : diff;
    assign det_mag  = det_reg[DET_W-1] ? -det_reg : det_reg;

    always_ff @(posedge aclk) begin
        if (cmd.det_en) begin
            det_reg <= diff[DET_W-1:0];
        end
        if (cmd.div_start) begin
            neg_reg <= diff[PROD_W] ^ det_reg[DET_W-1];
        end
    end

    tbt_div #(
        .TEX_FRAC_BITS(TEX_FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (diff_mag[NUM_W-1:0]),
        .den     (det_mag[UD_W-1:0]),
        .done    (div_done),
        .quot    (div_q),
        .big     (div_big)
    );

    // quotient carries one extra fraction bit: round half away, then saturate
    always_comb begin
        q_inc = {1'b0, div_q} + 1'b1;
        q_rnd = q_inc[Q_W:1];
        limit = neg_reg ? Q_W'(33'h0_8000_0000) : Q_W'(33'h0_7FFF_FFFF);
        sat   = div_big || (q_rnd > limit);
        mag   = sat ? limit : q_rnd;
        val   = neg_reg ? -mag : mag;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            for (int i = 0; i < N_COMP; i++) begin
                res_reg[i] <= '0;
            end
            clip_reg <= 1'b0;
        end else if (cmd.fin_en) begin
            res_reg[cmd.comp] <= val[POS_W-1:0];
            clip_reg          <= clip_reg | sat;
        end
        if (cmd.out_load) begin
            out_reg.tangent_x   <= res_reg[0];
            out_reg.tangent_y   <= res_reg[1];
            out_reg.tangent_z   <= res_reg[2];
            out_reg.bitangent_x <= res_reg[3];
            out_reg.bitangent_y <= res_reg[4];
            out_reg.bitangent_z <= res_reg[5];
            out_reg.degenerate  <= (det_reg == '0);
            out_reg.clipped     <= clip_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.det_zero = (det_reg == '0);
    assign sts.div_done = div_done;
    assign sts.out_busy = m_valid_reg && !m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = out_reg;

    property p_load_free;
        @(posedge aclk) disable iff (!aresetn) cmd.out_load |-> (!m_valid_reg || m_ready);
    endproperty
    a_load_free: assert property (p_load_free) else $error("output word overwritten");

    property p_load_valid;
        @(posedge aclk) disable iff (!aresetn) cmd.out_load |=> m_valid_reg;
    endproperty
    a_load_valid: assert property (p_load_valid) else $error("loaded word not shown");

    property p_degenerate_clean;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid_reg && out_reg.degenerate) |->
                (!out_reg.clipped && out_reg.tangent_x == '0 && out_reg.bitangent_z == '0);
    endproperty
    a_degenerate_clean: assert property (p_degenerate_clean)
        else $error("degenerate word has nonzero content");

endmodule

// ===== rtl/tbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbt_ctrl
// Sequencer: corner count, determinant, six multiply/divide passes, output.
// ----------------------------------------------------------------------------
module tbt_ctrl import tbt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output tbt_cmd_t cmd,
    input  tbt_sts_t sts
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DET_MUL = 3'd1;
    localparam logic [2:0] ST_DET_SUB = 3'd2;
    localparam logic [2:0] ST_MUL     = 3'd3;
    localparam logic [2:0] ST_SUB     = 3'd4;
    localparam logic [2:0] ST_DIV     = 3'd5;
    localparam logic [2:0] ST_FIN     = 3'd6;
    localparam logic [2:0] ST_OUT     = 3'd7;

    localparam logic [1:0] CNT_NONE   = 2'd0;
    localparam logic [1:0] CNT_ONE    = 2'd1;
    localparam logic [1:0] CNT_TWO    = 2'd2;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        count_reg, count_next;
    logic [COMP_W-1:0] comp_reg, comp_next;
    logic              take;

    assign s_ready = (state_reg == ST_IDLE);
    assign take    = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        comp_next  = comp_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    case (count_reg)
                        CNT_ONE: begin
                            cmd.store_second = 1'b1;
                            count_next       = CNT_TWO;
                        end
                        CNT_TWO: begin
                            cmd.capture = 1'b1;
                            count_next  = CNT_NONE;
                            state_next  = ST_DET_MUL;
                        end
                        default: begin
                            cmd.store_first = 1'b1;
                            count_next      = CNT_ONE;
                        end
                    endcase
                end
            end
            ST_DET_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_det = 1'b1;
                state_next  = ST_DET_SUB;
            end
            ST_DET_SUB: begin
                cmd.det_en = 1'b1;
                comp_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (sts.det_zero) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.mul_en = 1'b1;
                    state_next = ST_SUB;
                end
            end
            ST_SUB: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.fin_en = 1'b1;
                if (comp_reg == COMP_W'(N_COMP - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= CNT_NONE;
            comp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            comp_reg  <= comp_next;
        end
    end

    property p_capture_starts;
        @(posedge aclk) disable iff (!aresetn) cmd.capture |=> (state_reg == ST_DET_MUL);
    endproperty
    a_capture_starts: assert property (p_capture_starts) else $error("capture lost");

    property p_count_range;
        @(posedge aclk) disable iff (!aresetn) count_reg != 2'd3;
    endproperty
    a_count_range: assert property (p_count_range) else $error("corner count out of range");

    property p_comp_range;
        @(posedge aclk) disable iff (!aresetn) comp_reg < COMP_W'(N_COMP);
    endproperty
    a_comp_range: assert property (p_comp_range) else $error("component index out of range");

endmodule
